FILE: src/oamdma_pkg.sv
`default_nettype none

package oamdma_pkg;

  localparam int unsigned AddrWidth  = 16;
  localparam int unsigned DataWidth  = 8;

  localparam logic [15:0] DMA_REG_ADDR = 16'hFF46;
  localparam int unsigned COPY_LENGTH  = 160;
  // transfer ends once the low source byte reaches the length, taken mod 256
  localparam logic [7:0]  COPY_STOP    = 8'(COPY_LENGTH % 256);

  localparam logic [7:0]  OAM_PAGE     = 8'hFE;
  localparam logic [15:0] HRAM_LOW     = 16'hFF80;
  localparam logic [15:0] HRAM_HIGH    = 16'hFFFE;
  localparam logic [7:0]  LOCKED_BYTE  = 8'hFF;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

endpackage

`default_nettype wire

FILE: src/oamdma_if.sv
`default_nettype none

interface oamdma_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, output opcode, output address, output write_data,
                  input ready);
  modport sink   (input valid, input opcode, input address, input write_data,
                  output ready);
endinterface

interface oamdma_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       dma_busy;

  modport source (output valid, output read_data, output dma_busy, input ready);
  modport sink   (input valid, input read_data, input dma_busy, output ready);
endinterface

`default_nettype wire

FILE: src/oamdma_ram.sv
`default_nettype none

module oamdma_ram #(
  parameter int unsigned AddrWidth = 16,
  parameter int unsigned DataWidth = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrWidth-1:0] waddr_i,
  input  wire logic [DataWidth-1:0] wdata_i,
  input  wire logic                 re_i,
  input  wire logic [AddrWidth-1:0] raddr_i,
  output logic      [DataWidth-1:0] rdata_o
);

  localparam int unsigned Depth = 1 << AddrWidth;

  logic [DataWidth-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/oam_dma_with_bus_lockout.sv
`default_nettype none

// channel | dir | payload                         | handshake
// in_i    | in  | opcode, address, write_data     | valid/ready
// out_o   | out | read_data, dma_busy             | valid/ready
//
// a write, an idle tick, an unused opcode or a locked-out read is answered from
// ST_IDLE; a bus read or a copying tick waits on the registered read of the
// 64 KiB byte ram (own read and write ports), and ST_COPY writes the copy back.
// reset clears the engine state and the output register; ram contents are kept.
// one word is in flight at a time; a new word is taken while the previous
// result is being collected, and the input stalls while the output is held.

module oam_dma_with_bus_lockout
  import oamdma_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  oamdma_in_if.sink   in_i,
  oamdma_out_if.source out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY
  } state_e;

  state_e state_q;

  logic [15:0] src_q;
  logic        active_q;
  logic        pending_q;
  logic        out_valid_q;
  logic [7:0]  out_data_q;
  logic        out_busy_q;

  logic                 accept;
  logic                 in_hram;
  logic                 mem_we;
  logic [AddrWidth-1:0] mem_waddr;
  logic [DataWidth-1:0] mem_wdata;
  logic [AddrWidth-1:0] mem_raddr;
  logic [DataWidth-1:0] mem_rdata;
  logic [15:0]          src_inc;
  opcode_e              op;

  assign op      = opcode_e'(in_i.opcode);
  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign accept  = in_i.valid && in_i.ready;
  assign in_hram = (in_i.address >= HRAM_LOW) && (in_i.address <= HRAM_HIGH);
  assign src_inc = src_q + 16'd1;

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_data_q;
  assign out_o.dma_busy  = out_busy_q;

  // read port: bus address on a read, copy source on a tick
  always_comb begin
    mem_raddr = (op == OP_READ) ? in_i.address : src_q;
  end

  // write port: copy write-back in its own cycle, else a bus write on accept
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = in_i.address;
    mem_wdata = in_i.write_data;
    if (state_q == ST_COPY) begin
      mem_we    = 1'b1;
      mem_waddr = {OAM_PAGE, src_q[7:0]};
      mem_wdata = mem_rdata;
    end else if (accept && op == OP_WRITE) begin
      if (active_q) begin
        mem_we = in_hram;
      end else begin
        mem_we = (in_i.address != DMA_REG_ADDR);
      end
    end
  end

  oamdma_ram #(
    .AddrWidth(AddrWidth),
    .DataWidth(DataWidth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      src_q       <= 16'h0000;
      active_q    <= 1'b0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= 8'h00;
      out_busy_q  <= 1'b0;
    end else begin
      // on accept the previous word is always gone, each branch below decides
      if (out_valid_q && out_o.ready && !accept) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (op)
              OP_TICK: begin
                if (active_q) begin
                  out_valid_q <= 1'b0;
                  state_q     <= ST_COPY;
                end else begin
                  if (pending_q) begin
                    active_q  <= 1'b1;
                    pending_q <= 1'b0;
                  end
                  out_valid_q <= 1'b1;
                  out_data_q  <= 8'h00;
                  out_busy_q  <= pending_q;
                end
              end
              OP_READ: begin
                if (active_q && !in_hram) begin
                  out_valid_q <= 1'b1;
                  out_data_q  <= LOCKED_BYTE;
                  out_busy_q  <= active_q;
                end else begin
                  out_valid_q <= 1'b0;
                  state_q     <= ST_READ;
                end
              end
              OP_WRITE: begin
                if (!active_q && in_i.address == DMA_REG_ADDR) begin
                  src_q     <= {in_i.write_data, 8'h00};
                  pending_q <= 1'b1;
                end
                out_valid_q <= 1'b1;
                out_data_q  <= 8'h00;
                out_busy_q  <= active_q;
              end
              default: begin
                out_valid_q <= 1'b1;
                out_data_q  <= 8'h00;
                out_busy_q  <= active_q;
              end
            endcase
          end
        end
        ST_READ: begin
          out_valid_q <= 1'b1;
          out_data_q  <= mem_rdata;
          out_busy_q  <= active_q;
          state_q     <= ST_IDLE;
        end
        ST_COPY: begin
          src_q       <= src_inc;
          out_valid_q <= 1'b1;
          out_data_q  <= 8'h00;
          state_q     <= ST_IDLE;
          // a pending start keeps the transfer running past its stop point
          if (pending_q) begin
            active_q   <= 1'b1;
            pending_q  <= 1'b0;
            out_busy_q <= 1'b1;
          end else begin
            active_q   <= (src_inc[7:0] != COPY_STOP);
            out_busy_q <= (src_inc[7:0] != COPY_STOP);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
